[rtl/jsh_pkg.sv]
// Shared types, constants and helpers for the JPEG symbol histogram table.
package jsh_pkg;

  localparam int NUM_SYMBOLS_DEF     = 256;
  localparam int COUNT_WIDTH_DEF     = 32;
  localparam int MAX_CODE_LENGTH_DEF = 16;

  localparam int USED_W = 9;
  localparam int LEN_W  = 5;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [USED_W-1:0] MAX_USED = 9'd255;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_TOO_MANY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_W,
    S_PREV,
    S_PREV_W,
    S_CMP,
    S_PLACE,
    S_FIN,
    S_RD_W
  } state_t;

  // Status reported for a given used count and chosen length
  function automatic logic [1:0] status_of(input logic [USED_W-1:0] used,
                                           input logic [LEN_W-1:0] len);
    logic [1:0] st;
    if (used == '0) st = STAT_EMPTY;
    else if (used > MAX_USED || len == '0) st = STAT_TOO_MANY;
    else st = STAT_OK;
    return st;
  endfunction

endpackage

[rtl/jsh_if.sv]
// Input and result channel interfaces of the symbol histogram table.
interface jsh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] category;
  logic [3:0] run_length;
  logic [3:0] coef_size;
  logic       is_eob;
  logic       is_zrl;
  logic [7:0] read_index;

  modport source (output valid, opcode, category, run_length, coef_size, is_eob, is_zrl,
                  read_index, input ready);
  modport sink   (input valid, opcode, category, run_length, coef_size, is_eob, is_zrl,
                  read_index, output ready);
endinterface

interface jsh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] symbol_count;
  logic [4:0] code_length;
  logic [7:0] symbol;

  modport source (output valid, status, symbol_count, code_length, symbol, input ready);
  modport sink   (input valid, status, symbol_count, code_length, symbol, output ready);
endinterface

[rtl/jpeg_symbol_histogram_table.sv]
// Top level of the JPEG symbol histogram table.
// Count words are taken one per cycle while idle: each is a read-modify-write of the
// histogram memory through its registered read port, and the increment of a back-to-back
// repeat of the same symbol is forwarded from the previous write. Clear resets the
// per-entry valid bits. Finish runs an insertion sort over the histogram and sorted-list
// memories: each histogram entry is read and checked, and each comparison against the
// sorted list reads the previous symbol, reads its count and compares (with a placing
// step when a symbol moves to the front), then the result is delivered.
// Read goes through the sorted-list memory read port. Finish, read and clear
// wait until the count pipeline is empty; counts may continue while a result waits.
module jpeg_symbol_histogram_table
  import jsh_pkg::*;
#(
  parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
  parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  jsh_in_if.sink    din,
  jsh_out_if.source dout
);

  localparam int SW = $clog2(NUM_SYMBOLS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  logic ac_mode;

  // Histogram port signals
  logic                   h_clr, h_rd_en, h_wr_en;
  logic [SW-1:0]          h_rd_addr, h_wr_addr;
  logic [COUNT_WIDTH-1:0] h_rd_data, h_wr_data;

  // Sorted list port signals
  logic          s_rd_en, s_wr_en;
  logic [SW-1:0] s_rd_addr, s_wr_addr;
  logic [7:0]    s_rd_data, s_wr_data;

  // Count pipeline
  logic                   p_valid;
  logic [SW-1:0]          p_addr;
  logic                   w_valid;
  logic [SW-1:0]          w_addr;
  logic [COUNT_WIDTH-1:0] w_val;
  logic [COUNT_WIDTH-1:0] cnt_base, cnt_new;

  // Sort state
  logic [SW-1:0]          scan_sym;
  logic [USED_W-1:0]      n_used;
  logic [USED_W-1:0]      pos;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [7:0]             prev_sym;
  logic                   rd_ok;

  logic [USED_W-1:0] used_count;
  logic [LEN_W-1:0]  chosen_length;
  logic [LEN_W-1:0]  len_calc;

  logic       accept;
  logic       count_go;
  logic [7:0] sym;
  logic       sym_ok;
  logic       out_free;
  logic       scan_last;

  assign accept   = din.valid && din.ready;
  assign out_free = !dout.valid || dout.ready;
  assign scan_last = (scan_sym == SW'(NUM_SYMBOLS - 1));

  // Form the counted symbol
  always_comb begin
    if (ac_mode) begin
      if (din.is_eob) sym = SYM_EOB;
      else if (din.is_zrl) sym = SYM_ZRL;
      else sym = {din.run_length, din.coef_size};
    end else begin
      sym = din.category;
    end
  end
  assign sym_ok   = ({1'b0, sym} < USED_W'(NUM_SYMBOLS));
  assign count_go = accept && (din.opcode == OP_COUNT) && sym_ok;

  // Accept counts while idle; other words wait for the count pipeline to drain
  assign din.ready = (state == S_IDLE) && ((din.opcode == OP_COUNT) || !p_valid);

  // Increment with forwarding of the previous write and saturation
  always_comb begin
    cnt_base = (w_valid && (w_addr == p_addr)) ? w_val : h_rd_data;
    cnt_new  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
  end

  // Shortest length whose code space exceeds the used count
  always_comb begin
    len_calc = '0;
    for (int i = 0; i < 8; i++) begin
      if (n_used[i]) len_calc = LEN_W'(i + 1);
    end
    if (n_used == '0 || n_used > MAX_USED || len_calc > LEN_W'(MAX_CODE_LENGTH)) begin
      len_calc = '0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) ac_mode <= 1'b0;
    else if (cfg_we) ac_mode <= cfg_data;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    h_clr      = 1'b0;
    h_rd_en    = 1'b0;
    h_rd_addr  = scan_sym;
    h_wr_en    = p_valid;
    h_wr_addr  = p_addr;
    h_wr_data  = cnt_new;
    s_rd_en    = 1'b0;
    s_rd_addr  = SW'(pos - 1'b1);
    s_wr_en    = 1'b0;
    s_wr_addr  = pos[SW-1:0];
    s_wr_data  = 8'(scan_sym);
    unique case (state)
      S_IDLE: begin
        if (count_go) begin
          h_rd_en   = 1'b1;
          h_rd_addr = sym[SW-1:0];
        end
        if (accept) begin
          unique case (din.opcode)
            OP_FINISH: state_next = S_SCAN;
            OP_READ: begin
              s_rd_en    = 1'b1;
              s_rd_addr  = din.read_index[SW-1:0];
              state_next = S_RD_W;
            end
            OP_CLEAR: h_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        h_rd_en    = 1'b1;
        state_next = S_SCAN_W;
      end
      S_SCAN_W: begin
        if (h_rd_data == '0) begin
          state_next = scan_last ? S_FIN : S_SCAN;
        end else if (n_used == '0) begin
          // First used symbol goes straight to the head of the list
          s_wr_en    = 1'b1;
          s_wr_addr  = '0;
          state_next = scan_last ? S_FIN : S_SCAN;
        end else begin
          state_next = S_PREV;
        end
      end
      S_PREV: begin
        s_rd_en    = 1'b1;
        state_next = S_PREV_W;
      end
      S_PREV_W: begin
        h_rd_en    = 1'b1;
        h_rd_addr  = s_rd_data[SW-1:0];
        state_next = S_CMP;
      end
      S_CMP: begin
        s_wr_en = 1'b1;
        if (h_rd_data < cur_cnt) begin
          s_wr_data  = prev_sym;
          state_next = (pos == USED_W'(1)) ? S_PLACE : S_PREV;
        end else begin
          state_next = scan_last ? S_FIN : S_SCAN;
        end
      end
      S_PLACE: begin
        s_wr_en    = 1'b1;
        state_next = scan_last ? S_FIN : S_SCAN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      S_RD_W: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Count pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      p_valid <= count_go;
      w_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (count_go) p_addr <= sym[SW-1:0];
    if (p_valid) begin
      w_addr <= p_addr;
      w_val  <= cnt_new;
    end
  end

  // Sort datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        scan_sym <= '0;
        n_used   <= '0;
        rd_ok    <= ({1'b0, din.read_index} < used_count);
      end
      S_SCAN_W: begin
        cur_cnt <= h_rd_data;
        pos     <= n_used;
        if (h_rd_data != '0 && n_used == '0) n_used <= USED_W'(1);
        if (h_rd_data == '0 || n_used == '0) scan_sym <= scan_sym + 1'b1;
      end
      S_PREV_W: prev_sym <= s_rd_data;
      S_CMP: begin
        if (h_rd_data < cur_cnt) begin
          pos <= pos - 1'b1;
        end else begin
          n_used   <= n_used + 1'b1;
          scan_sym <= scan_sym + 1'b1;
        end
      end
      S_PLACE: begin
        n_used   <= n_used + 1'b1;
        scan_sym <= scan_sym + 1'b1;
      end
      default: ;
    endcase
  end

  // Finish results
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count    <= '0;
      chosen_length <= '0;
    end else if (state == S_FIN && out_free) begin
      used_count    <= n_used;
      chosen_length <= len_calc;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      dout.valid <= 1'b1;
    end else if (state == S_RD_W && out_free) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      dout.status       <= status_of(n_used, len_calc);
      dout.symbol_count <= n_used;
      dout.code_length  <= len_calc;
      dout.symbol       <= '0;
    end else if (state == S_RD_W && out_free) begin
      dout.status       <= status_of(used_count, chosen_length);
      dout.symbol_count <= used_count;
      dout.code_length  <= chosen_length;
      dout.symbol       <= rd_ok ? s_rd_data : '0;
    end
  end

  jsh_hist_mem #(
    .DEPTH (NUM_SYMBOLS),
    .WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .clr     (h_clr),
    .rd_en   (h_rd_en),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd_data),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data)
  );

  jsh_sort_mem #(
    .DEPTH (NUM_SYMBOLS)
  ) u_sort (
    .clk     (clk),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (s_rd_data),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data)
  );

  // Sorting never overlaps an in-flight count
  a_no_count_in_sort: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !p_valid)
    else $error("count increment pending during sort");

  // Shifting only happens with a nonzero insert position
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREV || state == S_CMP) |-> (pos != '0 && pos <= n_used))
    else $error("bad insert position");

  // A nonzero length is only reported with ok status
  a_len_ok: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.code_length != '0) |-> (dout.status == STAT_OK))
    else $error("length reported with error status");

  // A clear never coincides with a histogram write
  a_clr_no_write: assert property (@(posedge clk) disable iff (rst)
    h_clr |-> !h_wr_en)
    else $error("clear during count write");

endmodule

[rtl/jsh_hist_mem.sv]
// Histogram count memory with per-entry valid bits so that a clear resets every entry.
module jsh_hist_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] q;
  logic             hit;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) q <= mem[rd_addr];
  end

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= vld[rd_addr];
    end
  end

  assign rd_data = hit ? q : '0;

endmodule

[rtl/jsh_sort_mem.sv]
// Sorted symbol list memory, one write and one registered read port.
module jsh_sort_mem #(
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
